@@ rtl/cba_pkg.sv @@
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants for the chunked block allocator.
// Holds the transaction payload structs, sizing constants and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

   // Sizing of the chunk slot table and of one chunk.
   localparam int MAX_CHUNKS = 8;
   localparam int MAX_BLOCKS = 255;
   localparam int SLOT_W     = 3;
   localparam int BLK_W      = 8;
   localparam int LIVE_W     = 4;
   localparam int LINK_DEPTH = MAX_CHUNKS * 256;

   // Marker for an alloc hint that points at no chunk.
   localparam logic [LIVE_W-1:0] HINT_NONE = LIVE_W'(MAX_CHUNKS);

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] free_chunk;
      logic [BLK_W-1:0]  free_block;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] got_chunk;
      logic [BLK_W-1:0]  got_block;
      logic [1:0]        status;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/chunked_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// chunked_block_allocator_top: fixed-size block allocator over chunk slots.
// Sequencer around one shared count compare, a small chunk table and a link RAM.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; req_stall is high while it is in work.
// An allocate that hits its hint goes from the hint check through the two pop
// steps to the result register; otherwise it scans the chunk order first, and
// opening a new chunk writes every entry of the fresh free list through the
// single write port of the link RAM. A valid free checks the request, searches
// the chunk order for the chunk, pushes the block and takes a tail step when
// the chunk becomes wholly free; an invalid free ends after the check.
// A csr write resets all chunks and hints and is taken only while idle; a
// request accepted in the same cycle works on the cleared table.
`default_nettype none

module chunked_block_allocator_top import cba_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_AHINT, ST_ASCAN, ST_AINIT, ST_APOP, ST_APOP2,
      ST_FCHK, ST_FSCAN, ST_FPUSH, ST_FTAIL, ST_DONE
   } state_type;

   localparam int LINK_AW = $clog2(LINK_DEPTH);

   // Control registers.
   state_type           state_ff, state_in;
   logic [BLK_W-1:0]    bpc_ff, bpc_in;
   logic [LIVE_W-1:0]   live_ff, live_in;
   logic [MAX_CHUNKS-1:0] used_ff, used_in;
   logic [LIVE_W-1:0]   hint_ff, hint_in;
   logic [LIVE_W-1:0]   idx_ff, idx_in;
   logic [BLK_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working and payload registers.
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;

   // Chunk table storage.
   logic [BLK_W-1:0]    head_ff  [MAX_CHUNKS];
   logic [BLK_W-1:0]    count_ff [MAX_CHUNKS];
   logic [SLOT_W-1:0]   order_ff [MAX_CHUNKS];

   // Chunk table write controls.
   logic                head_we, count_we, order_we, order2_we;
   logic [SLOT_W-1:0]   tbl_slot, order_wa, order2_wa;
   logic [BLK_W-1:0]    head_wd, count_wd;
   logic [SLOT_W-1:0]   order_wd, order2_wd;

   // Link RAM ports.
   logic                link_we, link_re;
   logic [LINK_AW-1:0]  link_wa, link_ra;
   logic [BLK_W-1:0]    link_wd, link_rd;

   // Read side of the chunk table and the shared compare unit.
   logic [SLOT_W-1:0]   ord_idx, ord_rd, cnt_slot;
   logic [BLK_W-1:0]    count_rd, head_rd;
   logic                cnt_nz, cnt_full;
   logic [SLOT_W-1:0]   last_pos, tail_idx, free_slot;
   logic                out_free;

   cba_ram #(.WIDTH(BLK_W), .DEPTH(LINK_DEPTH)) u_link (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // Last live order position and the position examined at the tail step.
   assign last_pos = SLOT_W'(live_ff - LIVE_W'(1));
   assign tail_idx = (pos_ff == last_pos) ? SLOT_W'(pos_ff - SLOT_W'(1)) : last_pos;

   // One order read address per cycle, chosen by the sequencer.
   always_comb begin
      case (state_ff)
         ST_AHINT: ord_idx = hint_ff[SLOT_W-1:0];
         ST_ASCAN, ST_FSCAN: ord_idx = idx_ff[SLOT_W-1:0];
         ST_APOP:  ord_idx = pos_ff;
         ST_FTAIL: ord_idx = tail_idx;
         default:  ord_idx = '0;
      endcase
   end
   assign ord_rd = order_ff[ord_idx];

   // One count and head read per cycle, from the order or the held slot.
   assign cnt_slot = (state_ff inside {ST_FCHK, ST_FPUSH, ST_APOP2}) ? slot_ff : ord_rd;
   assign count_rd = count_ff[cnt_slot];
   assign head_rd  = head_ff[cnt_slot];

   // Shared compare unit.
   assign cnt_nz   = (count_rd != '0);
   assign cnt_full = (count_rd == bpc_ff);

   // Lowest unused chunk slot.
   always_comb begin
      free_slot = '0;
      for (int k = MAX_CHUNKS - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            free_slot = SLOT_W'(k);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      bpc_in       = bpc_ff;
      live_in      = live_ff;
      used_in      = used_ff;
      hint_in      = hint_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      blk_in       = blk_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      head_we   = 1'b0;
      count_we  = 1'b0;
      order_we  = 1'b0;
      order2_we = 1'b0;
      tbl_slot  = slot_ff;
      head_wd   = '0;
      count_wd  = '0;
      order_wa  = '0;
      order_wd  = '0;
      order2_wa = '0;
      order2_wd = '0;
      link_we   = 1'b0;
      link_wa   = '0;
      link_wd   = '0;
      link_re   = 1'b0;
      link_ra   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               // A register write also clears every chunk and hint.
               if (csr_wr_data == '0) begin
                  bpc_in = BLK_W'(1);
               end else if (int'(csr_wr_data) > MAX_BLOCKS) begin
                  bpc_in = BLK_W'(MAX_BLOCKS);
               end else begin
                  bpc_in = csr_wr_data;
               end
               live_in = '0;
               used_in = '0;
               hint_in = HINT_NONE;
            end
            if (req_valid) begin
               slot_in = req_data.free_chunk;
               blk_in  = req_data.free_block;
               res_in  = '0;
               state_in = (req_data.mode == MODE_ALLOC) ? ST_AHINT : ST_FCHK;
            end
         end

         ST_AHINT: begin
            if (hint_ff < live_ff && cnt_nz) begin
               pos_in   = hint_ff[SLOT_W-1:0];
               state_in = ST_APOP;
            end else begin
               idx_in   = '0;
               state_in = ST_ASCAN;
            end
         end

         ST_ASCAN: begin
            if (idx_ff < live_ff) begin
               if (cnt_nz) begin
                  pos_in   = idx_ff[SLOT_W-1:0];
                  hint_in  = idx_ff;
                  state_in = ST_APOP;
               end else begin
                  idx_in = idx_ff + LIVE_W'(1);
               end
            end else if (live_ff >= LIVE_W'(MAX_CHUNKS)) begin
               res_in.status = STATUS_NO_SLOT;
               state_in      = ST_DONE;
            end else begin
               slot_in  = free_slot;
               cnt_in   = '0;
               state_in = ST_AINIT;
            end
         end

         ST_AINIT: begin
            // Fresh free list: entry j links to j plus one.
            link_we = 1'b1;
            link_wa = {slot_ff, cnt_ff};
            link_wd = cnt_ff + BLK_W'(1);
            if (cnt_ff == bpc_ff - BLK_W'(1)) begin
               head_we  = 1'b1;
               head_wd  = '0;
               count_we = 1'b1;
               count_wd = bpc_ff;
               used_in[slot_ff] = 1'b1;
               order_we = 1'b1;
               order_wa = live_ff[SLOT_W-1:0];
               order_wd = slot_ff;
               pos_in   = live_ff[SLOT_W-1:0];
               hint_in  = live_ff;
               live_in  = live_ff + LIVE_W'(1);
               state_in = ST_APOP;
            end else begin
               cnt_in = cnt_ff + BLK_W'(1);
            end
         end

         ST_APOP: begin
            slot_in  = ord_rd;
            blk_in   = head_rd;
            link_re  = 1'b1;
            link_ra  = {ord_rd, head_rd};
            state_in = ST_APOP2;
         end

         ST_APOP2: begin
            head_we  = 1'b1;
            head_wd  = link_rd;
            count_we = 1'b1;
            count_wd = count_rd - BLK_W'(1);
            res_in.got_chunk = slot_ff;
            res_in.got_block = blk_ff;
            res_in.status    = STATUS_OK;
            state_in = ST_DONE;
         end

         ST_FCHK: begin
            if (!used_ff[slot_ff] || blk_ff >= bpc_ff || count_rd >= bpc_ff) begin
               res_in.status = STATUS_BAD_FREE;
               state_in      = ST_DONE;
            end else begin
               idx_in   = '0;
               state_in = ST_FSCAN;
            end
         end

         ST_FSCAN: begin
            // Find the order position of the chunk being freed into.
            if (idx_ff + LIVE_W'(1) < live_ff && ord_rd != slot_ff) begin
               idx_in = idx_ff + LIVE_W'(1);
            end else begin
               pos_in   = idx_ff[SLOT_W-1:0];
               state_in = ST_FPUSH;
            end
         end

         ST_FPUSH: begin
            link_we  = 1'b1;
            link_wa  = {slot_ff, blk_ff};
            link_wd  = head_rd;
            head_we  = 1'b1;
            head_wd  = blk_ff;
            count_we = 1'b1;
            count_wd = count_rd + BLK_W'(1);
            res_in.status = STATUS_OK;
            state_in = (count_rd + BLK_W'(1) == bpc_ff) ? ST_FTAIL : ST_DONE;
         end

         ST_FTAIL: begin
            // The chunk is wholly free: drop one of two wholly free chunks or move it back.
            if (pos_ff == last_pos) begin
               if (live_ff > LIVE_W'(1) && cnt_full) begin
                  used_in[slot_ff] = 1'b0;
                  live_in = live_ff - LIVE_W'(1);
                  hint_in = '0;
               end
            end else if (cnt_full) begin
               used_in[ord_rd] = 1'b0;
               live_in = live_ff - LIVE_W'(1);
               hint_in = LIVE_W'(pos_ff);
            end else begin
               order_we  = 1'b1;
               order_wa  = pos_ff;
               order_wd  = ord_rd;
               order2_we = 1'b1;
               order2_wa = last_pos;
               order2_wd = slot_ff;
               hint_in   = LIVE_W'(last_pos);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bpc_ff       <= BLK_W'(MAX_BLOCKS);
         live_ff      <= '0;
         used_ff      <= '0;
         hint_ff      <= HINT_NONE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bpc_ff       <= bpc_in;
         live_ff      <= live_in;
         used_ff      <= used_in;
         hint_ff      <= hint_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff <= slot_in;
      blk_ff  <= blk_in;
      pos_ff  <= pos_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // Chunk table writes.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[tbl_slot] <= head_wd;
      end
      if (count_we) begin
         count_ff[tbl_slot] <= count_wd;
      end
      if (order_we) begin
         order_ff[order_wa] <= order_wd;
      end
      if (order2_we) begin
         order_ff[order2_wa] <= order2_wd;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The live count always matches the number of used slots.
   a_live_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(live_ff))
      else $error("live count differs from used slot count");

   // The live count never exceeds the slot count.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(MAX_CHUNKS))
      else $error("live count beyond slot count");

   // A scan index never runs past the live chunks.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ASCAN || state_ff == ST_FSCAN) |-> idx_ff <= live_ff)
      else $error("scan index beyond live chunks");

endmodule

`default_nettype wire

@@ rtl/cba_ram.sv @@
// ----------------------------------------------------------------------------
// cba_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
